FILE: design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C register access master: bus phase
// codes, byte stage codes, the tick word, the latched request and the result.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // bus phase of the sequencer, one phase per tick
    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_ST_HIGH   = 5'd1,
        PH_ST_LOW    = 5'd2,
        PH_ST_END    = 5'd3,
        PH_BIT_LOW   = 5'd4,
        PH_BIT_HIGH  = 5'd5,
        PH_ACK_LOW   = 5'd6,
        PH_ACK_HIGH  = 5'd7,
        PH_RS_LOW    = 5'd8,
        PH_RD_LOW    = 5'd9,
        PH_RD_HIGH   = 5'd10,
        PH_MACK_LOW  = 5'd11,
        PH_MACK_HIGH = 5'd12,
        PH_SP_LOW    = 5'd13,
        PH_SP_SCL    = 5'd14,
        PH_SP_END    = 5'd15
    } t_phase;

    // which byte of the transaction is on the wire
    typedef enum logic [2:0] {
        STG_ADDR  = 3'd0,
        STG_REG   = 3'd1,
        STG_DATA  = 3'd2,
        STG_RADDR = 3'd3,
        STG_READ  = 3'd4
    } t_stage;

    // transfer direction
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // reset value of the acknowledge timeout
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    // depth of the result queue
    localparam int RES_DEPTH = 2;

    // one line-phase tick as received
    typedef struct packed {
        logic       start_request;
        logic       mode;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       ack_enable;
        logic       sda_in;
    } t_item;

    // transaction held while busy
    typedef struct packed {
        logic       mode;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       ack_enable;
    } t_req;

    // one result word
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       ack_error;
        logic [7:0] read_data;
    } t_result;

endpackage

FILE: design/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// Bus phase sequencer. Holds the transaction state and, for each tick it is
// stepped with, produces the line levels and status of that tick.
// ----------------------------------------------------------------------------
module i2cm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  i2cm_pkg::t_item   i_item,
    input  logic [7:0]        i_ack_timeout,
    output i2cm_pkg::t_result o_result
);
    import i2cm_pkg::*;

    t_phase     r_phase,   n_phase;
    t_stage     r_stage,   n_stage;
    logic [3:0] r_bit_cnt, n_bit_cnt;
    logic [7:0] r_shift,   n_shift;
    logic [7:0] r_wait,    n_wait;
    t_req       r_req;
    logic [7:0] r_rx,      n_rx;
    logic       r_err,     n_err;

    logic       launch;
    t_phase     cur_phase;
    t_req       cur_req;
    t_stage     cur_stage;
    logic [3:0] cur_bit_cnt;
    logic [7:0] cur_shift;
    logic [7:0] cur_wait;
    logic       cur_err;
    logic [3:0] bit_inc;

    // request latch on an idle tick; this tick already runs the first phase
    always_comb begin
        launch      = (r_phase == PH_IDLE) && i_item.start_request;
        cur_phase   = launch ? PH_ST_HIGH : r_phase;
        cur_stage   = launch ? STG_ADDR : r_stage;
        cur_bit_cnt = launch ? 4'd0 : r_bit_cnt;
        cur_shift   = launch ? {i_item.device_address, 1'b0} : r_shift;
        cur_wait    = launch ? 8'd0 : r_wait;
        cur_err     = launch ? 1'b0 : r_err;
        if (launch) begin
            cur_req.mode             = i_item.mode;
            cur_req.device_address   = i_item.device_address;
            cur_req.register_address = i_item.register_address;
            cur_req.write_data       = i_item.write_data;
            cur_req.ack_enable       = i_item.ack_enable;
        end else begin
            cur_req = r_req;
        end
        bit_inc = cur_bit_cnt + 4'd1;
    end

    // next state
    always_comb begin
        n_phase   = cur_phase;
        n_stage   = cur_stage;
        n_bit_cnt = cur_bit_cnt;
        n_shift   = cur_shift;
        n_wait    = cur_wait;
        n_rx      = r_rx;
        n_err     = cur_err;
        unique case (cur_phase)
            PH_IDLE:      n_phase = PH_IDLE;
            PH_ST_HIGH:   n_phase = PH_ST_LOW;
            PH_ST_LOW:    n_phase = PH_ST_END;
            PH_ST_END:    n_phase = PH_BIT_LOW;
            PH_BIT_LOW:   n_phase = PH_BIT_HIGH;
            PH_BIT_HIGH: begin
                n_shift   = {cur_shift[6:0], 1'b0};
                n_bit_cnt = bit_inc;
                n_phase   = (bit_inc >= 4'd8) ? PH_ACK_LOW : PH_BIT_LOW;
            end
            PH_ACK_LOW: begin
                n_wait  = 8'd0;
                n_phase = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                if (i_item.sda_in) begin
                    // slave has not pulled low yet
                    if (cur_wait >= i_ack_timeout) begin
                        n_err   = 1'b1;
                        n_phase = PH_SP_LOW;
                    end else begin
                        n_wait = cur_wait + 8'd1;
                    end
                end else begin
                    n_wait = 8'd0;
                    priority if (cur_stage == STG_ADDR) begin
                        n_stage   = STG_REG;
                        n_shift   = cur_req.register_address;
                        n_bit_cnt = 4'd0;
                        n_phase   = PH_BIT_LOW;
                    end else if (cur_stage == STG_REG && cur_req.mode == MODE_WRITE) begin
                        n_stage   = STG_DATA;
                        n_shift   = cur_req.write_data;
                        n_bit_cnt = 4'd0;
                        n_phase   = PH_BIT_LOW;
                    end else if (cur_stage == STG_REG) begin
                        n_stage   = STG_RADDR;
                        n_shift   = {cur_req.device_address, 1'b1};
                        n_bit_cnt = 4'd0;
                        n_phase   = PH_RS_LOW;
                    end else if (cur_stage == STG_RADDR) begin
                        n_stage   = STG_READ;
                        n_shift   = 8'd0;
                        n_bit_cnt = 4'd0;
                        n_phase   = PH_RD_LOW;
                    end else begin
                        n_phase = PH_SP_LOW;
                    end
                end
            end
            PH_RS_LOW:    n_phase = PH_ST_HIGH;
            PH_RD_LOW:    n_phase = PH_RD_HIGH;
            PH_RD_HIGH: begin
                n_shift   = {cur_shift[6:0], i_item.sda_in};
                n_bit_cnt = bit_inc;
                if (bit_inc >= 4'd8) begin
                    n_rx    = {cur_shift[6:0], i_item.sda_in};
                    n_phase = PH_MACK_LOW;
                end else begin
                    n_phase = PH_RD_LOW;
                end
            end
            PH_MACK_LOW:  n_phase = PH_MACK_HIGH;
            PH_MACK_HIGH: n_phase = PH_SP_LOW;
            PH_SP_LOW:    n_phase = PH_SP_SCL;
            PH_SP_SCL:    n_phase = PH_SP_END;
            PH_SP_END:    n_phase = PH_IDLE;
            default:      n_phase = PH_IDLE;
        endcase
    end

    // line levels and status of this tick
    always_comb begin
        o_result           = '0;
        o_result.scl_level = 1'b1;
        o_result.sda_level = 1'b1;
        o_result.busy_res  = 1'b1;
        o_result.read_data = n_rx;
        unique case (cur_phase)
            PH_IDLE:      o_result.busy_res = 1'b0;
            PH_ST_HIGH:   o_result.sda_drive = 1'b1;
            PH_ST_LOW: begin
                o_result.sda_drive = 1'b1;
                o_result.sda_level = 1'b0;
            end
            PH_ST_END, PH_SP_LOW: begin
                o_result.sda_drive = 1'b1;
                o_result.sda_level = 1'b0;
                o_result.scl_level = 1'b0;
            end
            PH_BIT_LOW: begin
                o_result.sda_drive = 1'b1;
                o_result.sda_level = cur_shift[7];
                o_result.scl_level = 1'b0;
            end
            PH_BIT_HIGH: begin
                o_result.sda_drive = 1'b1;
                o_result.sda_level = cur_shift[7];
            end
            PH_ACK_LOW, PH_RD_LOW: o_result.scl_level = 1'b0;
            PH_ACK_HIGH, PH_RD_HIGH: o_result.scl_level = 1'b1;
            PH_RS_LOW: begin
                o_result.sda_drive = 1'b1;
                o_result.scl_level = 1'b0;
            end
            PH_MACK_LOW: begin
                o_result.sda_drive = 1'b1;
                o_result.sda_level = ~cur_req.ack_enable;
                o_result.scl_level = 1'b0;
            end
            PH_MACK_HIGH: begin
                o_result.sda_drive = 1'b1;
                o_result.sda_level = ~cur_req.ack_enable;
            end
            PH_SP_SCL: begin
                o_result.sda_drive = 1'b1;
                o_result.sda_level = 1'b0;
            end
            PH_SP_END: begin
                o_result.sda_drive = 1'b1;
                o_result.done_res  = 1'b1;
                o_result.ack_error = cur_err;
            end
            default:      o_result.busy_res = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_stage   <= STG_ADDR;
            r_bit_cnt <= 4'd0;
            r_shift   <= 8'd0;
            r_wait    <= 8'd0;
            r_req     <= '0;
            r_rx      <= 8'd0;
            r_err     <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_stage   <= n_stage;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_wait    <= n_wait;
            r_req     <= cur_req;
            r_rx      <= n_rx;
            r_err     <= n_err;
        end
    end

endmodule

FILE: design/i2c_master_register_access_top.sv
// ----------------------------------------------------------------------------
// i2c_master_register_access_top
// I2C master for single register writes and reads, one bus phase per tick.
// ----------------------------------------------------------------------------
// Each accepted word is one bus phase tick and yields exactly one result word.
// The block takes one word per clock while the result queue has room: the
// tick is captured in an input register, and the phase sequencer advances
// from that register into a two-word result queue. The phase register loop
// sets the rate. Input stall rises only while the result queue is full and a
// tick waits in the input register. The acknowledge timeout is written over
// the configuration port, which is always ready; write it only while no
// transaction is running.
module i2c_master_register_access_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // tick input
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_start_request,
    input  logic       i_mode,
    input  logic [6:0] i_device_address,
    input  logic [7:0] i_register_address,
    input  logic [7:0] i_write_data,
    input  logic       i_ack_enable,
    input  logic       i_sda_in,
    // result output
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_sda_drive,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_ack_error,
    output logic [7:0] o_read_data,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import i2cm_pkg::*;

    localparam int QIDX_W = $clog2(RES_DEPTH);
    localparam int QCNT_W = $clog2(RES_DEPTH + 1);

    logic              r_in_valid;
    t_item             r_item;
    t_item             in_item;
    logic [7:0]        r_ack_timeout;
    t_result           r_q [RES_DEPTH];
    logic [QIDX_W-1:0] r_head;
    logic [QCNT_W-1:0] r_cnt;
    logic              step;
    logic              pop;
    logic              in_take;
    logic [QIDX_W-1:0] wr_idx;
    t_result           core_res;
    t_result           head_res;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ack_timeout <= i_cfg_data;
        end
    end

    // input word assembly
    always_comb begin
        in_item.start_request    = i_start_request;
        in_item.mode             = i_mode;
        in_item.device_address   = i_device_address;
        in_item.register_address = i_register_address;
        in_item.write_data       = i_write_data;
        in_item.ack_enable       = i_ack_enable;
        in_item.sda_in           = i_sda_in;
    end

    // handshake control
    assign step    = r_in_valid && (r_cnt != QCNT_W'(RES_DEPTH));
    assign o_stall = r_in_valid && (r_cnt == QCNT_W'(RES_DEPTH));
    assign in_take = i_valid && !o_stall;
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;
    assign wr_idx  = QIDX_W'((32'(r_head) + 32'(r_cnt)) % RES_DEPTH);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= in_item;
        end
    end

    // phase sequencer
    i2cm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (r_item),
        .i_ack_timeout (r_ack_timeout),
        .o_result      (core_res)
    );

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
        end else begin
            if (pop) begin
                r_head <= QIDX_W'((32'(r_head) + 1) % RES_DEPTH);
            end
            r_cnt <= r_cnt + QCNT_W'(step) - QCNT_W'(pop);
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_q[wr_idx] <= core_res;
        end
    end

    assign head_res    = r_q[r_head];
    assign o_scl_level = head_res.scl_level;
    assign o_sda_level = head_res.sda_level;
    assign o_sda_drive = head_res.sda_drive;
    assign o_busy_res  = head_res.busy_res;
    assign o_done_res  = head_res.done_res;
    assign o_ack_error = head_res.ack_error;
    assign o_read_data = head_res.read_data;

endmodule

FILE: design/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C register access master, bound to the top.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_scl_level,
    input logic       o_sda_level,
    input logic       o_sda_drive,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic       o_ack_error,
    input logic [7:0] o_read_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable({o_scl_level, o_sda_level,
            o_sda_drive, o_busy_res, o_done_res, o_ack_error, o_read_data}))
        else $error("result word changed while stalled");

    // the finishing tick belongs to a running transaction
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> o_busy_res && o_sda_drive && o_scl_level)
        else $error("done without busy stop tick");

    // an error is only reported with done
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ack_error |-> o_done_res)
        else $error("ack error outside done tick");

    // released sda reads as pull-up level
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sda_drive |-> o_sda_level)
        else $error("sda low while released");

    // idle bus leaves both lines high and released
    a_idle_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_busy_res |-> o_scl_level && !o_sda_drive && !o_done_res)
        else $error("bus not released while idle");

endmodule

bind i2c_master_register_access_top i2cm_checker u_i2cm_checker (.*);
